// ----- rtl/drum_index_seek_controller_top_defines.svh -----
// Assertion helpers included by disc_core; clock is aclk, reset is aresetn.
`ifndef DRUM_INDEX_SEEK_CONTROLLER_TOP_DEFINES_SVH
`define DRUM_INDEX_SEEK_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define DISC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("disc assertion failed");

// Next-cycle implication.
`define DISC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("disc assertion failed");

`endif

// ----- rtl/disc_pkg.sv -----
`default_nettype none
package disc_pkg;

    localparam int DEF_MAX_PASSED = 32;
    localparam int DEF_FIELD_BITS = 19;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_REVERSE = 3'd0,
        CFG_TRAVEL_SPEED  = 3'd1,
        CFG_POLL_PERIOD   = 3'd2,
        CFG_HOP_TIMEOUT   = 3'd3,
        CFG_BRAKE_TIME    = 3'd4,
        CFG_TRIP_THRESH   = 3'd5,
        CFG_TRIP_HYST     = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_POLL    = 2'd0,
        KIND_HOME    = 2'd1,
        KIND_ADVANCE = 2'd2,
        KIND_QUERY   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_BUSY     = 3'd1,
        ST_DONE     = 3'd2,
        ST_HOME     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_TIMEOUT  = 3'd5,
        ST_SENSOR   = 3'd6,
        ST_REJECT   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        MODE_COAST = 2'd0,
        MODE_DRIVE = 2'd1,
        MODE_BRAKE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CHIME_NONE    = 2'd0,
        CHIME_HOME    = 2'd1,
        CHIME_ADVANCE = 2'd2
    } chime_t;

    localparam logic [6:0]  SPEED_MIN   = 7'd1;
    localparam logic [6:0]  SPEED_MAX   = 7'd100;
    localparam logic [6:0]  SPEED_RST   = 7'd60;
    localparam logic [9:0]  MS10_MIN    = 10'd1;
    localparam logic [9:0]  MS10_MAX    = 10'd1000;
    localparam logic [9:0]  POLL_RST    = 10'd10;
    localparam logic [9:0]  BRAKE_RST   = 10'd150;
    localparam logic [15:0] HOP_MIN     = 16'd1;
    localparam logic [15:0] HOP_MAX     = 16'd60000;
    localparam logic [15:0] HOP_RST     = 16'd5000;

    typedef struct packed {
        logic        drive_reverse;
        logic [6:0]  drive_duty_pct;
        logic [9:0]  poll_period_ms;
        logic [15:0] hop_timeout_ms;
        logic [9:0]  brake_time_ms;
        logic [17:0] trip_threshold_ut;
        logic [17:0] trip_hysteresis_ut;
    } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/disc_cfg.sv -----
`default_nettype none
module disc_cfg
    import disc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    logic [6:0]  speed_raw;
    logic [9:0]  ms10_raw;
    logic [15:0] hop_raw;
    logic [6:0]  speed_sat;
    logic [9:0]  ms10_sat;
    logic [15:0] hop_sat;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        speed_raw = cfg_data[6:0];
        ms10_raw  = cfg_data[9:0];
        hop_raw   = cfg_data[15:0];
        speed_sat = (speed_raw < SPEED_MIN) ? SPEED_MIN :
                    (speed_raw > SPEED_MAX) ? SPEED_MAX : speed_raw;
        ms10_sat  = (ms10_raw < MS10_MIN) ? MS10_MIN :
                    (ms10_raw > MS10_MAX) ? MS10_MAX : ms10_raw;
        hop_sat   = (hop_raw < HOP_MIN) ? HOP_MIN :
                    (hop_raw > HOP_MAX) ? HOP_MAX : hop_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_reverse      <= 1'b0;
            cfg_reg.drive_duty_pct     <= SPEED_RST;
            cfg_reg.poll_period_ms     <= POLL_RST;
            cfg_reg.hop_timeout_ms     <= HOP_RST;
            cfg_reg.brake_time_ms      <= BRAKE_RST;
            cfg_reg.trip_threshold_ut  <= '0;
            cfg_reg.trip_hysteresis_ut <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DRIVE_REVERSE: cfg_reg.drive_reverse      <= cfg_data[0];
                CFG_TRAVEL_SPEED:  cfg_reg.drive_duty_pct     <= speed_sat;
                CFG_POLL_PERIOD:   cfg_reg.poll_period_ms     <= ms10_sat;
                CFG_HOP_TIMEOUT:   cfg_reg.hop_timeout_ms     <= hop_sat;
                CFG_BRAKE_TIME:    cfg_reg.brake_time_ms      <= ms10_sat;
                CFG_TRIP_THRESH:   cfg_reg.trip_threshold_ut  <= cfg_data[17:0];
                CFG_TRIP_HYST:     cfg_reg.trip_hysteresis_ut <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/disc_core.sv -----
`default_nettype none
module disc_core
    import disc_pkg::*;
#(
    parameter int MAX_PASSED = DEF_MAX_PASSED,
    parameter int FIELD_BITS = DEF_FIELD_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cfg_t                         cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   in_kind,
    input  wire logic                         in_present,
    input  wire logic signed [FIELD_BITS-1:0] in_field,
    input  wire logic                         in_err,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        out_mode,
    output logic [6:0]                        out_speed,
    output logic                              out_reverse,
    output logic [2:0]                        out_status,
    output logic signed [FIELD_BITS-1:0]      out_rest,
    output logic [5:0]                        out_passed,
    output logic [21:0]                       out_elapsed,
    output logic                              out_at_home,
    output logic [1:0]                        out_chime
);

`include "drum_index_seek_controller_top_defines.svh"

    localparam int CMPW = (FIELD_BITS + 1 > 19) ? FIELD_BITS + 1 : 19;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CLEAR = 2'd1,
        PH_HUNT  = 2'd2,
        PH_BRAKE = 2'd3
    } phase_t;

    // input stage
    logic                          in_valid_reg;
    kind_t                         kind_reg;
    logic                          present_reg;
    logic signed [FIELD_BITS-1:0]  field_reg;
    logic                          err_reg;

    // seek state
    phase_t      phase_reg, phase_next;
    logic        home_reg, home_next;
    logic [5:0]  passed_reg, passed_next;
    logic [15:0] hop_reg, hop_next;
    logic [21:0] move_reg, move_next;
    logic [9:0]  brake_reg, brake_next;
    status_t     pend_reg, pend_next;

    // result stage
    logic                          out_valid_reg;
    mode_t                         mode_reg, mode_next;
    logic [6:0]                    speed_reg, speed_next;
    logic                          reverse_reg, reverse_next;
    status_t                       status_reg, status_next;
    logic signed [FIELD_BITS-1:0]  rest_reg, rest_next;
    logic                          at_home_reg, at_home_next;
    chime_t                        chime_reg, chime_next;

    logic              advance;
    logic              neg;
    logic [CMPW-1:0]   field_ext;
    logic [CMPW-1:0]   mag;
    logic [17:0]       trip_diff;
    logic              near;
    logic [22:0]       move_sum;
    logic [16:0]       hop_sum;
    logic [21:0]       move_sat;
    logic [15:0]       hop_sat;
    logic [5:0]        passed_inc;
    logic              stopped;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            kind_reg    <= kind_t'(in_kind);
            present_reg <= in_present;
            field_reg   <= in_field;
            err_reg     <= in_err;
        end
    end

    always_comb begin
        neg       = field_reg[FIELD_BITS-1];
        field_ext = {{(CMPW - FIELD_BITS){neg}}, field_reg};
        mag       = neg ? (~field_ext + CMPW'(1)) : field_ext;
        trip_diff = cfg.trip_threshold_ut - cfg.trip_hysteresis_ut;
        // hysteresis above threshold leaves a negative bound: always near
        near      = (cfg.trip_hysteresis_ut > cfg.trip_threshold_ut) ||
                    (mag > CMPW'(trip_diff));
        move_sum  = {1'b0, move_reg} + 23'(cfg.poll_period_ms);
        hop_sum   = {1'b0, hop_reg} + 17'(cfg.poll_period_ms);
        move_sat  = move_sum[22] ? '1 : move_sum[21:0];
        hop_sat   = hop_sum[16] ? '1 : hop_sum[15:0];
        passed_inc = passed_reg + 6'd1;
    end

    always_comb begin
        phase_next  = phase_reg;
        home_next   = home_reg;
        passed_next = passed_reg;
        hop_next    = hop_reg;
        move_next   = move_reg;
        brake_next  = brake_reg;
        pend_next   = pend_reg;
        status_next = ST_IDLE;
        rest_next   = '0;
        chime_next  = CHIME_NONE;
        stopped     = 1'b0;

        case (kind_reg)
            KIND_QUERY: begin
                status_next = (phase_reg == PH_IDLE) ? ST_IDLE : ST_BUSY;
            end
            KIND_HOME, KIND_ADVANCE: begin
                if (phase_reg != PH_IDLE) begin
                    status_next = ST_REJECT;
                end else begin
                    home_next   = (kind_reg == KIND_HOME);
                    passed_next = '0;
                    move_next   = '0;
                    hop_next    = '0;
                    if (err_reg) begin
                        status_next = ST_SENSOR;
                    end else if (kind_reg == KIND_HOME && present_reg && neg) begin
                        status_next = ST_HOME;
                        rest_next   = field_reg;
                        chime_next  = CHIME_HOME;
                    end else begin
                        phase_next  = (present_reg || near) ? PH_CLEAR : PH_HUNT;
                        status_next = ST_BUSY;
                    end
                end
            end
            default: begin
                case (phase_reg)
                    PH_IDLE: begin
                        status_next = ST_IDLE;
                    end
                    PH_BRAKE: begin
                        if (brake_reg > cfg.poll_period_ms) begin
                            brake_next  = brake_reg - cfg.poll_period_ms;
                            status_next = ST_BUSY;
                        end else begin
                            brake_next  = '0;
                            phase_next  = PH_IDLE;
                            status_next = pend_reg;
                            if (pend_reg == ST_DONE) begin
                                if (err_reg) begin
                                    status_next = ST_SENSOR;
                                end else begin
                                    rest_next  = field_reg;
                                    chime_next = home_reg ? CHIME_HOME : CHIME_ADVANCE;
                                end
                            end
                        end
                    end
                    default: begin
                        move_next   = move_sat;
                        hop_next    = hop_sat;
                        status_next = ST_BUSY;
                        if (err_reg) begin
                            phase_next  = PH_IDLE;
                            status_next = ST_SENSOR;
                        end else begin
                            if (phase_reg == PH_CLEAR) begin
                                if (!present_reg && !near) begin
                                    phase_next = PH_HUNT;
                                    hop_next   = '0;
                                end
                            end else if (present_reg) begin
                                if (!home_reg || neg) begin
                                    phase_next = PH_BRAKE;
                                    brake_next = cfg.brake_time_ms;
                                    pend_next  = ST_DONE;
                                    stopped    = 1'b1;
                                end else begin
                                    passed_next = passed_inc;
                                    if (passed_inc >= 6'(MAX_PASSED)) begin
                                        phase_next = PH_BRAKE;
                                        brake_next = cfg.brake_time_ms;
                                        pend_next  = ST_NOTFOUND;
                                        stopped    = 1'b1;
                                    end else begin
                                        phase_next = PH_CLEAR;
                                        hop_next   = '0;
                                    end
                                end
                            end
                            if (!stopped && hop_next >= cfg.hop_timeout_ms) begin
                                phase_next = PH_BRAKE;
                                brake_next = cfg.brake_time_ms;
                                pend_next  = ST_TIMEOUT;
                            end
                        end
                    end
                endcase
            end
        endcase

        case (phase_next)
            PH_CLEAR, PH_HUNT: mode_next = MODE_DRIVE;
            PH_BRAKE:          mode_next = MODE_BRAKE;
            default:           mode_next = MODE_COAST;
        endcase
        speed_next   = (mode_next == MODE_DRIVE) ? cfg.drive_duty_pct : 7'd0;
        reverse_next = (mode_next != MODE_COAST) ? cfg.drive_reverse : 1'b0;
        at_home_next = !err_reg && present_reg && neg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            home_reg      <= 1'b0;
            passed_reg    <= '0;
            hop_reg       <= '0;
            move_reg      <= '0;
            brake_reg     <= '0;
            pend_reg      <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg     <= phase_next;
                home_reg      <= home_next;
                passed_reg    <= passed_next;
                hop_reg       <= hop_next;
                move_reg      <= move_next;
                brake_reg     <= brake_next;
                pend_reg      <= pend_next;
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                speed_reg     <= speed_next;
                reverse_reg   <= reverse_next;
                status_reg    <= status_next;
                rest_reg      <= rest_next;
                at_home_reg   <= at_home_next;
                chime_reg     <= chime_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_mode    = mode_reg;
    assign out_speed   = speed_reg;
    assign out_reverse = reverse_reg;
    assign out_status  = status_reg;
    assign out_rest    = rest_reg;
    assign out_passed  = passed_reg;
    assign out_elapsed = move_reg;
    assign out_at_home = at_home_reg;
    assign out_chime   = chime_reg;

    `DISC_ASSERT_NOW(a_passed_bound, 1'b1, passed_reg <= 6'(MAX_PASSED))
    `DISC_ASSERT_NOW(a_chime_on_success,
        out_valid_reg && (status_reg == ST_DONE || status_reg == ST_HOME),
        chime_reg != CHIME_NONE)
    `DISC_ASSERT_NOW(a_drive_speed,
        out_valid_reg && mode_reg == MODE_DRIVE, speed_reg != 7'd0)
    `DISC_ASSERT_NEXT(a_item_held,
        in_valid_reg && out_valid_reg && !out_ready, in_valid_reg)

endmodule
`default_nettype wire

// ----- rtl/drum_index_seek_controller_top.sv -----
`default_nettype none
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tuser kind, s_tdata reading
// m_        out        m_tvalid / m_tready    m_tuser status, m_tdata motor and report
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while m_ accepts; each item passes through the
// input register and then the result register.
// The seek state updates only when an item moves into the result register.
// A stalled m_ side holds one result and one waiting item, then drops s_tready.
// aresetn is synchronous; config regs return to defaults, no clearing pass.
module drum_index_seek_controller_top
    import disc_pkg::*;
#(
    parameter int MAX_PASSED = DEF_MAX_PASSED,
    parameter int FIELD_BITS = DEF_FIELD_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // presence flag, hall field, sensor error
    input  wire logic [((FIELD_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,
    // kind
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // motor_mode, motor_speed_pct, motor_reverse, rest field, passed_count,
    // elapsed_move_ms, at_home, chime_request
    output logic [((FIELD_BITS + 41 + 7) / 8) * 8 - 1:0] m_tdata,
    // status
    output logic [2:0]                  m_tuser,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int M_W = ((FIELD_BITS + 41 + 7) / 8) * 8;

    cfg_t                         cfg;
    logic [1:0]                   mode;
    logic [6:0]                   speed;
    logic                         reverse;
    logic signed [FIELD_BITS-1:0] rest;
    logic [5:0]                   passed;
    logic [21:0]                  elapsed;
    logic                         at_home;
    logic [1:0]                   chime;

    disc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    disc_core #(
        .MAX_PASSED (MAX_PASSED),
        .FIELD_BITS (FIELD_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_present  (s_tdata[0]),
        .in_field    (s_tdata[FIELD_BITS:1]),
        .in_err      (s_tdata[FIELD_BITS+1]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_mode    (mode),
        .out_speed   (speed),
        .out_reverse (reverse),
        .out_status  (m_tuser),
        .out_rest    (rest),
        .out_passed  (passed),
        .out_elapsed (elapsed),
        .out_at_home (at_home),
        .out_chime   (chime)
    );

    assign m_tdata = M_W'({chime, at_home, elapsed, passed, rest, reverse, speed, mode});

endmodule
`default_nettype wire
